// ----- hw/rtl/bae_pkg.sv -----
// shared types and constants of the binary arithmetic encoder
package bae_pkg;

    localparam int RANGE_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int PROB_BITS_DEF = 12;
    localparam int MAX_BYTES     = RANGE_W / BYTE_W;
    localparam int QUEUE_DEPTH   = 8;
    localparam int PUSH_CNT_W    = $clog2(MAX_BYTES + 1);

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic [PUSH_CNT_W-1:0]       cnt;
        entry_t [MAX_BYTES-1:0]      ent;
    } push_t;

endpackage

// ----- hw/rtl/bae_split.sv -----
// split point of the coding interval from low, high and probability
module bae_split #(
    parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
    input  logic [bae_pkg::RANGE_W-1:0] range_low,
    input  logic [bae_pkg::RANGE_W-1:0] range_high,
    input  logic [PROB_BITS-1:0]        prob,
    output logic [bae_pkg::RANGE_W-1:0] mid
);
    import bae_pkg::*;

    logic [RANGE_W-1:0]           span;
    logic [RANGE_W-PROB_BITS-1:0] span_hi;
    logic [PROB_BITS-1:0]         span_lo;
    logic [RANGE_W-1:0]           whole;
    logic [2*PROB_BITS-1:0]       frac_prod;
    logic [RANGE_W-1:0]           frac;

    assign span      = range_high - range_low;
    assign span_hi   = span[RANGE_W-1:PROB_BITS];
    assign span_lo   = span[PROB_BITS-1:0];
    assign whole     = RANGE_W'(span_hi) * RANGE_W'(prob);
    assign frac_prod = (2*PROB_BITS)'(span_lo) * (2*PROB_BITS)'(prob);
    assign frac      = {{(RANGE_W-PROB_BITS){1'b0}}, frac_prod[2*PROB_BITS-1:PROB_BITS]};
    assign mid       = range_low + whole + frac;

endmodule

// ----- hw/rtl/bae_queue.sv -----
// output byte queue taking up to four bytes per cycle and giving one per cycle while m_tready is high
module bae_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bae_pkg::push_t            push,
    output logic                      room,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bae_pkg::BYTE_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import bae_pkg::*;

    // depth is a power of two so pointers wrap on their own
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_idx [MAX_BYTES];
    logic               pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].data;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;
    assign room     = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_BYTES));

    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            wr_idx[i] = wr_ptr_reg + PTR_W'(i);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (PUSH_CNT_W'(i) < push.cnt)
            begin
                mem_reg[wr_idx[i]] <= push.ent[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/binary_arithmetic_encoder.sv -----
// binary arithmetic encoder top level with 32-bit interval
//
// channel  dir  tdata (low bit up)          tuser    tlast
// s_*      in   prob, bit_value, zero pad   opcode   -
// m_*      out  out_byte                    -        last_byte
//
// one item per cycle while the output queue has room; the interval update loop
// holds only the low/high registers, with split multiply and byte compare combinational
// each encode item leaves 0 to 4 bytes in an 8-entry queue, a flush one byte
// an item waits in the input register while the queue has fewer than 4 free entries
// reset sets low to zero, high to all ones and empties the queue
module binary_arithmetic_encoder #(
    parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF,
    localparam int IN_W     = ((PROB_BITS + 1 + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // prob, bit_value, pad
    input  logic                       s_tuser,   // opcode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bae_pkg::BYTE_W-1:0] m_tdata,   // out_byte
    output logic                       m_tlast    // last_byte
);
    import bae_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_op_reg;
    logic [PROB_BITS-1:0]  in_prob_reg;
    logic                  in_bit_reg;
    logic [RANGE_W-1:0]    low_reg, low_next;
    logic [RANGE_W-1:0]    high_reg, high_next;
    logic [RANGE_W-1:0]    mid;
    logic [RANGE_W-1:0]    low_u, high_u;
    logic [PUSH_CNT_W-1:0] n_bytes;
    logic                  run;
    logic                  room;
    logic                  fire;
    logic                  s_accept;
    push_t                 push;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign s_accept = s_tvalid && s_tready;

    bae_split #(
        .PROB_BITS (PROB_BITS)
    ) u_split (
        .range_low  (low_reg),
        .range_high (high_reg),
        .prob       (in_prob_reg),
        .mid        (mid)
    );

    always_comb
    begin
        if (in_bit_reg == 1'b0)
        begin
            low_u  = mid + RANGE_W'(1);
            high_u = high_reg;
        end
        else
        begin
            low_u  = low_reg;
            high_u = mid;
        end

        // count leading bytes that low and high share
        n_bytes = '0;
        run     = 1'b1;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (run && (low_u[RANGE_W-1-BYTE_W*i -: BYTE_W]
                        == high_u[RANGE_W-1-BYTE_W*i -: BYTE_W]))
            begin
                n_bytes = n_bytes + PUSH_CNT_W'(1);
            end
            else
            begin
                run = 1'b0;
            end
        end

        for (int i = 0; i < MAX_BYTES; i++)
        begin
            push.ent[i].data = high_u[RANGE_W-1-BYTE_W*i -: BYTE_W];
            push.ent[i].last = (PUSH_CNT_W'(i + 1) == n_bytes);
        end

        low_next  = low_reg;
        high_next = high_reg;
        push.cnt  = '0;
        if (fire)
        begin
            if (in_op_reg == OP_FLUSH)
            begin
                push.cnt         = PUSH_CNT_W'(1);
                push.ent[0].data = low_reg[RANGE_W-1 -: BYTE_W];
                push.ent[0].last = 1'b1;
            end
            else
            begin
                push.cnt  = n_bytes;
                low_next  = low_u << {n_bytes, 3'b000};
                high_next = ~((~high_u) << {n_bytes, 3'b000});
            end
        end

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    bae_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg   <= s_tuser;
            in_prob_reg <= s_tdata[PROB_BITS-1:0];
            in_bit_reg  <= s_tdata[PROB_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            low_reg      <= '0;
            high_reg     <= '1;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
        end
    end

endmodule

// ----- verif/tb_binary_arithmetic_encoder.sv -----
// testbench of the binary arithmetic encoder: directed and random bits, checked byte by byte
`timescale 1ns / 100ps

class coded_byte_board;

    logic [bae_pkg::RANGE_W-1:0] low_end;
    logic [bae_pkg::RANGE_W-1:0] high_end;
    bae_pkg::entry_t             pending_bytes[$];
    int                          errors;
    int                          predicted;
    int                          checked;
    int                          items;
    int                          flushes;
    int                          top_burst;

    function new();
        low_end   = '0;
        high_end  = '1;
        errors    = 0;
        predicted = 0;
        checked   = 0;
        items     = 0;
        flushes   = 0;
        top_burst = 0;
    endfunction

    // interval split and renormalization, or the flush byte, for one accepted transaction
    function void encode_item(logic op, logic [bae_pkg::PROB_BITS_DEF-1:0] p, logic b);
        logic [bae_pkg::RANGE_W-1:0] span;
        logic [bae_pkg::RANGE_W-1:0] whole;
        logic [bae_pkg::RANGE_W-1:0] frac;
        logic [bae_pkg::RANGE_W-1:0] mid;
        bae_pkg::entry_t             e;
        int                          n;
        items++;
        if (op == bae_pkg::OP_FLUSH)
        begin
            flushes++;
            e.data = low_end[31:24];
            e.last = 1'b1;
            pending_bytes.push_back(e);
            predicted++;
            return;
        end
        span  = high_end - low_end;
        whole = (span >> bae_pkg::PROB_BITS_DEF) * {20'b0, p};
        frac  = ({20'b0, span[bae_pkg::PROB_BITS_DEF-1:0]} * {20'b0, p})
                >> bae_pkg::PROB_BITS_DEF;
        mid   = low_end + whole + frac;
        if (b == 1'b0)
            low_end = mid + 32'd1;
        else
            high_end = mid;
        n = 0;
        while (n < bae_pkg::MAX_BYTES && low_end[31:24] == high_end[31:24])
        begin
            e.data   = high_end[31:24];
            e.last   = 1'b0;
            pending_bytes.push_back(e);
            low_end  = low_end << 8;
            high_end = {high_end[23:0], 8'hFF};
            n++;
        end
        if (n > 0)
        begin
            e = pending_bytes.pop_back();
            e.last = 1'b1;
            pending_bytes.push_back(e);
        end
        predicted += n;
        if (n > top_burst)
            top_burst = n;
    endfunction

    function void match_byte(logic [7:0] d, logic fin);
        bae_pkg::entry_t e;
        checked++;
        if (pending_bytes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected byte, expected none, actual data %02h last %0d",
                     $time, d, fin);
            return;
        end
        e = pending_bytes.pop_front();
        if (e.data !== d || e.last !== fin)
        begin
            errors++;
            $display("%0t: byte mismatch, expected data %02h last %0d, actual data %02h last %0d",
                     $time, e.data, e.last, d, fin);
        end
    endfunction

    function int outstanding();
        return pending_bytes.size();
    endfunction

endclass

module tb_binary_arithmetic_encoder;

    localparam int PROB_W      = bae_pkg::PROB_BITS_DEF;
    localparam int IN_W        = ((PROB_W + 1 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 70;
    localparam int HOLD_LEN    = 300;
    localparam int MIN_BYTES   = 60;

    logic                       clk;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_W-1:0]            s_tdata  = '0;
    logic                       s_tuser  = bae_pkg::OP_ENCODE;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [bae_pkg::BYTE_W-1:0] m_tdata;
    logic                       m_tlast;

    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_tokens = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    coded_byte_board board = new();

    binary_arithmetic_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("timeout waiting for coded bytes");
        $display("Test completed with failures");
        $finish;
    end

    // byte receiver: random stalls plus a counted long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.match_byte(m_tdata, m_tlast);
            if (hold_tokens != hold_seen)
            begin
                hold_seen = hold_tokens;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic op, logic [PROB_W-1:0] p, logic b);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - PROB_W - 1){1'b0}}, b, p};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.encode_item(op, p, b);
    endtask

    task automatic send_random();
        logic              op;
        logic [PROB_W-1:0] p;
        logic              b;
        op = ($urandom_range(99) < 7) ? bae_pkg::OP_FLUSH : bae_pkg::OP_ENCODE;
        if ($urandom_range(99) < 20)
            p = $urandom_range(1) ? PROB_W'($urandom_range(15))
                                  : PROB_W'(4095 - $urandom_range(15));
        else
            p = PROB_W'($urandom_range(4095));
        if ($urandom_range(99) < 70)
            b = ($urandom_range(4095) < p);
        else
            b = 1'($urandom_range(1));
        send_item(op, p, b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners: flush from reset, zero and full probability, full burst
        send_item(bae_pkg::OP_FLUSH,  12'd0,    1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd2048, 1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'd0,    1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd4095, 1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'd4095, 1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd0,    1'b0);
        send_item(bae_pkg::OP_FLUSH,  12'd4095, 1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'hAAA,  1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'h555,  1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'd1,    1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd4094, 1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'd1,    1'b0);
        send_item(bae_pkg::OP_ENCODE, 12'd4094, 1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd0,    1'b1);
        send_item(bae_pkg::OP_ENCODE, 12'd0,    1'b1);
        send_item(bae_pkg::OP_FLUSH,  12'hAAA,  1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct <= 0;  stall_pct <= 0;  end
                1: begin gap_pct <= 85; stall_pct <= 0;  end
                2: begin gap_pct <= 0;  stall_pct <= 85; end
                default: begin gap_pct <= 22; stall_pct <= 22; end
            endcase
            @(posedge clk);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
            drain();
        end

        // receiver holds off while bursts pile up behind it
        gap_pct     <= 0;
        stall_pct   <= 0;
        hold_tokens <= hold_tokens + 1;
        @(posedge clk);
        for (int i = 0; i < 30; i++)
        begin
            if (i % 4 == 0)
                send_item(bae_pkg::OP_FLUSH, PROB_W'($urandom_range(4095)), 1'b0);
            else if (i % 4 == 1)
                send_item(bae_pkg::OP_ENCODE, 12'd0, 1'b1);
            else
                send_random();
        end
        drain();

        gap_pct   <= 22;
        stall_pct <= 22;
        while (board.predicted < MIN_BYTES)
            send_random();
        drain();
        repeat (20) @(posedge clk);

        if (board.outstanding() != 0)
        begin
            board.errors++;
            $display("%0t: %0d expected bytes never arrived, expected 0 left, actual %0d",
                     $time, board.outstanding(), board.outstanding());
        end
        $display("encoded %0d input transactions including %0d flushes", board.items,
                 board.flushes);
        $display("checked %0d output bytes, longest burst from one encode %0d bytes",
                 board.checked, board.top_burst);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
